FILE: design/lndr_pkg.sv
// Shared constants and types for the longest non-decreasing run scorer.
`default_nettype none
package lndr_pkg;

  localparam int MAX_ITEMS  = 512;
  localparam int VALUE_BITS = 16;
  localparam int LEN_W      = 10;
  localparam int CNT_W      = 10;
  localparam int ADDR_W     = $clog2(MAX_ITEMS);
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [LEN_W-1:0]      len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage
`default_nettype wire

FILE: design/longest_nondecreasing_run_dp_top.sv
// Top level of the longest non-decreasing run scorer.
// Each accepted word is scored against every element held in the store (item_count,
// at most 512); the result is registered in S_DONE, which waits while an earlier result
// waits for out_tready. A new word is accepted only in S_IDLE, after the last is scored;
// one stored element is read and compared per cycle.
// Synchronous active-low reset empties the store and clears the running maximum.
`default_nettype none
module longest_nondecreasing_run_dp_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [lndr_pkg::VALUE_BITS-1:0]     in_tdata,  // value
  input  wire logic                                in_tuser,  // first
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [lndr_pkg::OUT_DATA_W-1:0]     out_tdata, // length_here, longest, zero pad
  output logic                                     out_tuser  // store_full
);

  lndr_pkg::state_t                  state_r, state_nxt;
  logic [lndr_pkg::VALUE_BITS-1:0]   value_r, value_nxt;
  logic [lndr_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [lndr_pkg::LEN_W-1:0]        best_r, best_nxt;
  logic [lndr_pkg::CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                              rd_pend_r, rd_pend_nxt;
  logic [lndr_pkg::LEN_W-1:0]        prev_r, prev_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [lndr_pkg::LEN_W-1:0]        out_len_r, out_len_nxt;
  logic [lndr_pkg::LEN_W-1:0]        out_best_r, out_best_nxt;
  logic                              out_full_r, out_full_nxt;

  logic                              ram_rd_en;
  logic                              ram_wr_en;
  lndr_pkg::entry_t                  rd_entry;
  lndr_pkg::entry_t                  wr_entry;
  logic [lndr_pkg::LEN_W-1:0]        len_raw;
  logic [lndr_pkg::LEN_W-1:0]        len_sat;
  logic                              full;
  logic                              more;

  lndr_ram #(
    .WIDTH (lndr_pkg::ENTRY_W),
    .DEPTH (lndr_pkg::MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (cnt_r[lndr_pkg::ADDR_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx_r[lndr_pkg::ADDR_W-1:0]),
    .rd_data (rd_entry)
  );

  assign len_raw = prev_r + lndr_pkg::LEN_W'(1);
  assign len_sat = (len_raw > lndr_pkg::LEN_W'(lndr_pkg::MAX_ITEMS)) ?
                   lndr_pkg::LEN_W'(lndr_pkg::MAX_ITEMS) : len_raw;
  assign full    = (cnt_r >= lndr_pkg::CNT_W'(lndr_pkg::MAX_ITEMS));
  assign more    = (rd_idx_r < cnt_r);

  always_comb begin
    wr_entry.value = value_r;
    wr_entry.len   = len_sat;
  end

  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    rd_idx_nxt    = rd_idx_r;
    rd_pend_nxt   = rd_pend_r;
    prev_nxt      = prev_r;
    out_len_nxt   = out_len_r;
    out_best_nxt  = out_best_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_rd_en     = 1'b0;
    ram_wr_en     = 1'b0;
    in_tready     = (state_r == lndr_pkg::S_IDLE);

    unique case (state_r)
      lndr_pkg::S_IDLE: begin
        if (in_tvalid) begin
          value_nxt   = in_tdata;
          rd_idx_nxt  = '0;
          rd_pend_nxt = 1'b0;
          prev_nxt    = '0;
          if (in_tuser) begin
            cnt_nxt  = '0;
            best_nxt = '0;
          end
          state_nxt = lndr_pkg::S_SCAN;
        end
      end
      lndr_pkg::S_SCAN: begin
        rd_pend_nxt = 1'b0;
        if (more) begin
          ram_rd_en   = 1'b1;
          rd_idx_nxt  = rd_idx_r + lndr_pkg::CNT_W'(1);
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r && (rd_entry.value <= value_r) && (rd_entry.len > prev_r)) begin
          prev_nxt = rd_entry.len;
        end
        if (!more && !rd_pend_r) begin
          state_nxt = lndr_pkg::S_DONE;
        end
      end
      lndr_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          if (!full) begin
            ram_wr_en = 1'b1;
            cnt_nxt   = cnt_r + lndr_pkg::CNT_W'(1);
          end
          best_nxt      = (len_sat > best_r) ? len_sat : best_r;
          out_len_nxt   = len_sat;
          out_best_nxt  = (len_sat > best_r) ? len_sat : best_r;
          out_full_nxt  = full;
          out_valid_nxt = 1'b1;
          state_nxt     = lndr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lndr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lndr_pkg::S_IDLE;
      cnt_r       <= '0;
      best_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      best_r      <= best_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    rd_idx_r   <= rd_idx_nxt;
    prev_r     <= prev_nxt;
    out_len_r  <= out_len_nxt;
    out_best_r <= out_best_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lndr_pkg::OUT_DATA_W - 2 * lndr_pkg::LEN_W){1'b0}},
                       out_best_r, out_len_r};
  assign out_tuser  = out_full_r;

endmodule
`default_nettype wire

FILE: design/lndr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lndr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
